### rtl/core/wmmf_pkg.sv
// Shared types and constants for the wrench median/mean filter.
// Used by the interfaces, the controller, the datapath, the divider and the top level.
// It has no dependencies of its own.
package wmmf_pkg;

  // Field widths
  localparam int CH_W   = 3;
  localparam int NUM_CH = 6;
  localparam int SMP_W  = 16;
  localparam int IDX_W  = 6;
  localparam int WIN_MAX = 64;
  localparam int LEN_W  = 7;
  localparam int THR_W  = 15;
  localparam int MASK_W = 6;
  localparam int SUM_W  = 22;
  localparam int CNT_W  = 5;

  // Configuration port
  localparam int REG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [REG_IDX_W-1:0] REG_WIN_LEN  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DB_THR   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DB_MASK  = 2'd2;

  // Reset values of the registers
  localparam logic [LEN_W-1:0]  WIN_LEN_RST = 7'd40;
  localparam logic [THR_W-1:0]  DB_THR_RST  = 15'd26;
  localparam logic [MASK_W-1:0] DB_MASK_RST = 6'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MERGE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } wmmf_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic merge;
    logic update;
    logic finish;
  } wmmf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bad_ch;
    logic merge_done;
    logic div_done;
    logic out_free;
  } wmmf_stat_t;

endpackage

### rtl/core/wmmf_if.sv
// Valid/ready channel interfaces of the wrench median/mean filter.
// Depends on wmmf_pkg for field widths.
interface wmmf_in_if;
  logic                              valid;
  logic                              ready;
  logic [wmmf_pkg::CH_W-1:0]         channel;
  logic signed [wmmf_pkg::SMP_W-1:0] sample;
  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface wmmf_out_if;
  logic                              valid;
  logic                              ready;
  logic [wmmf_pkg::CH_W-1:0]         channel_out;
  logic signed [wmmf_pkg::SMP_W-1:0] median_value;
  logic signed [wmmf_pkg::SMP_W-1:0] filtered_value;
  modport source (output valid, output channel_out, output median_value,
                  output filtered_value, input ready);
  modport sink (input valid, input channel_out, input median_value,
                input filtered_value, output ready);
endinterface

interface wmmf_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [wmmf_pkg::REG_IDX_W-1:0]       index;
  logic [wmmf_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/wmmf_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
// Depends on wmmf_pkg for widths.
module wmmf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wmmf_pkg::SUM_W-1:0] dividend,
  input  logic [wmmf_pkg::LEN_W-1:0] divisor,
  output logic                       done,
  output logic [wmmf_pkg::SUM_W-1:0] quotient
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [wmmf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [wmmf_pkg::LEN_W-1:0] rem_r, rem_nxt;
  logic [wmmf_pkg::LEN_W-1:0] dvsr_r, dvsr_nxt;
  logic [wmmf_pkg::SUM_W-1:0] q_r, q_nxt;
  logic [wmmf_pkg::LEN_W:0]   rem_sh;
  logic                       ge;

  // One shift-and-subtract step per cycle.
  always_comb begin
    rem_sh   = {rem_r, q_r[wmmf_pkg::SUM_W-1]};
    ge       = rem_sh >= {1'b0, dvsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = wmmf_pkg::CNT_W'(wmmf_pkg::SUM_W - 1);
      rem_nxt  = '0;
      dvsr_nxt = divisor;
      q_nxt    = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? wmmf_pkg::LEN_W'(rem_sh - {1'b0, dvsr_r})
                   : rem_sh[wmmf_pkg::LEN_W-1:0];
      q_nxt   = {q_r[wmmf_pkg::SUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    q_r    <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### rtl/core/wmmf_ctrl.sv
// Controller state machine of the wrench median/mean filter.
// Depends on wmmf_pkg for the state, command and status types.
module wmmf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wmmf_pkg::wmmf_stat_t stat,
  output wmmf_pkg::wmmf_cmd_t  cmd
);

  wmmf_pkg::wmmf_state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wmmf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.bad_ch ? wmmf_pkg::ST_FINISH : wmmf_pkg::ST_LOAD;
        end
      end
      wmmf_pkg::ST_LOAD:   state_nxt = wmmf_pkg::ST_MERGE;
      wmmf_pkg::ST_MERGE: begin
        if (stat.merge_done) begin
          state_nxt = wmmf_pkg::ST_UPDATE;
        end
      end
      wmmf_pkg::ST_UPDATE: state_nxt = wmmf_pkg::ST_DIVIDE;
      wmmf_pkg::ST_DIVIDE: begin
        if (stat.div_done) begin
          state_nxt = wmmf_pkg::ST_FINISH;
        end
      end
      wmmf_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          state_nxt = wmmf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wmmf_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      wmmf_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      wmmf_pkg::ST_LOAD:   cmd.load   = 1'b1;
      wmmf_pkg::ST_MERGE:  cmd.merge  = 1'b1;
      wmmf_pkg::ST_UPDATE: cmd.update = 1'b1;
      wmmf_pkg::ST_DIVIDE: cmd        = '0;
      wmmf_pkg::ST_FINISH: cmd.finish = 1'b1;
      default:             cmd        = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/wmmf_datapath.sv
// Datapath of the wrench median/mean filter: registers, window memories,
// sorted-window merge, running sums and output register.
// Depends on wmmf_pkg and wmmf_div.
module wmmf_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wmmf_pkg::wmmf_cmd_t                  cmd,
  output wmmf_pkg::wmmf_stat_t                 stat,
  input  logic [wmmf_pkg::CH_W-1:0]            in_channel,
  input  logic signed [wmmf_pkg::SMP_W-1:0]    in_sample,
  input  logic                                 cfg_valid,
  input  logic [wmmf_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [wmmf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wmmf_pkg::CH_W-1:0]            out_channel_out,
  output logic signed [wmmf_pkg::SMP_W-1:0]    out_median_value,
  output logic signed [wmmf_pkg::SMP_W-1:0]    out_filtered_value
);

  localparam int RAW_AW  = wmmf_pkg::CH_W + wmmf_pkg::IDX_W;
  localparam int SORT_AW = RAW_AW + 1;

  // Configuration registers
  logic [wmmf_pkg::LEN_W-1:0]  win_len_r;
  logic [wmmf_pkg::THR_W-1:0]  thr_r;
  logic [wmmf_pkg::MASK_W-1:0] mask_r;
  logic [wmmf_pkg::LEN_W-1:0]  len;

  // Per-channel history state
  logic [wmmf_pkg::LEN_W-1:0]        fill_r   [wmmf_pkg::NUM_CH];
  logic [wmmf_pkg::IDX_W-1:0]        oldest_r [wmmf_pkg::NUM_CH];
  logic signed [wmmf_pkg::SUM_W-1:0] sum_r    [wmmf_pkg::NUM_CH];
  logic [wmmf_pkg::NUM_CH-1:0]       bank_r;

  // Window memories: raw ring, mean ring, two banks of the sorted window
  logic signed [wmmf_pkg::SMP_W-1:0] raw_mem  [2**RAW_AW];
  logic signed [wmmf_pkg::SMP_W-1:0] mean_mem [2**RAW_AW];
  logic signed [wmmf_pkg::SMP_W-1:0] sort_mem [2**SORT_AW];
  logic signed [wmmf_pkg::SMP_W-1:0] raw_q, mean_q, sort_q;

  // Current item
  logic [wmmf_pkg::CH_W-1:0]         ch_r;
  logic signed [wmmf_pkg::SMP_W-1:0] x_r;
  logic                              full_r;
  logic [wmmf_pkg::LEN_W-1:0]        n_old_r, n_new_r;
  logic [wmmf_pkg::IDX_W-1:0]        slot_r;
  logic signed [wmmf_pkg::SMP_W-1:0] med_r, mean_r;
  logic                              neg_r;

  // Merge state
  logic [wmmf_pkg::LEN_W-1:0]        rd_idx_r, rd_idx_nxt, w_r;
  logic                              deleted_r, inserted_r;
  logic signed [wmmf_pkg::SMP_W-1:0] lo_r, hi_r;

  // Output register
  logic                              out_valid_r;
  logic [wmmf_pkg::CH_W-1:0]         out_ch_r;
  logic signed [wmmf_pkg::SMP_W-1:0] out_med_r, out_mean_r;

  logic                              bad_ch, db_en;
  logic [wmmf_pkg::SMP_W:0]          mag;
  logic signed [wmmf_pkg::SMP_W-1:0] x_db;
  logic [wmmf_pkg::LEN_W-1:0]        n_cur;
  logic                              full_cur;
  logic                              head_ok, take_del, take_ins, take_head;
  logic                              merge_done, sort_we;
  logic signed [wmmf_pkg::SMP_W-1:0] sort_wdata;
  logic [wmmf_pkg::IDX_W-1:0]        rd_addr;
  logic                              bank_cur;
  logic [wmmf_pkg::LEN_W-1:0]        lo_idx, hi_idx;
  logic signed [wmmf_pkg::SMP_W:0]   pair_sum;
  logic signed [wmmf_pkg::SMP_W-1:0] med;
  logic signed [wmmf_pkg::SUM_W-1:0] evict, sum_new;
  logic [wmmf_pkg::SUM_W-1:0]        sum_mag;
  logic                              div_done;
  logic [wmmf_pkg::SUM_W-1:0]        quot;
  logic signed [wmmf_pkg::SUM_W-1:0] quot_s;
  logic [wmmf_pkg::IDX_W:0]          slot_inc;
  logic                              out_free;

  // Effective window length: zero acts as one, above the maximum clamps.
  always_comb begin
    if (win_len_r == '0) begin
      len = wmmf_pkg::LEN_W'(1);
    end else if (win_len_r > wmmf_pkg::LEN_W'(wmmf_pkg::WIN_MAX)) begin
      len = wmmf_pkg::LEN_W'(wmmf_pkg::WIN_MAX);
    end else begin
      len = win_len_r;
    end
  end

  // Deadband and window position of the incoming word.
  always_comb begin
    bad_ch   = in_channel >= wmmf_pkg::CH_W'(wmmf_pkg::NUM_CH);
    db_en    = !bad_ch && mask_r[in_channel];
    mag      = in_sample[wmmf_pkg::SMP_W-1] ? -{in_sample[wmmf_pkg::SMP_W-1], in_sample}
                                            : {1'b0, in_sample};
    x_db     = (db_en && (mag < (wmmf_pkg::SMP_W+1)'(thr_r))) ? '0 : in_sample;
    n_cur    = bad_ch ? '0 : fill_r[in_channel];
    full_cur = n_cur >= len;
  end

  // Merge step: drop the evicted value once, insert the new value in order.
  always_comb begin
    bank_cur   = bank_r[ch_r];
    head_ok    = rd_idx_r < n_old_r;
    merge_done = w_r == n_new_r;
    take_del   = full_r && !deleted_r && head_ok && (sort_q == raw_q);
    take_ins   = !take_del && !inserted_r && (!head_ok || (x_r <= sort_q));
    take_head  = !take_del && !take_ins;
    sort_we    = cmd.merge && !merge_done && (take_ins || take_head);
    sort_wdata = take_ins ? x_r : sort_q;
    rd_idx_nxt = rd_idx_r;
    if (cmd.merge && !merge_done && (take_del || take_head)) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
    rd_addr  = cmd.load ? '0 : rd_idx_nxt[wmmf_pkg::IDX_W-1:0];
    lo_idx   = (n_new_r - 1'b1) >> 1;
    hi_idx   = n_new_r >> 1;
  end

  // Median of the two middle values, floor of the average.
  always_comb begin
    pair_sum = (wmmf_pkg::SMP_W+1)'(lo_r) + (wmmf_pkg::SMP_W+1)'(hi_r);
    med      = wmmf_pkg::SMP_W'(pair_sum >>> 1);
    evict    = full_r ? wmmf_pkg::SUM_W'(mean_q) : '0;
    sum_new  = sum_r[ch_r] - evict + wmmf_pkg::SUM_W'(med);
    sum_mag  = sum_new[wmmf_pkg::SUM_W-1] ? wmmf_pkg::SUM_W'(-sum_new)
                                          : wmmf_pkg::SUM_W'(sum_new);
    slot_inc = {1'b0, slot_r} + 1'b1;
    quot_s   = neg_r ? -$signed(quot) : $signed(quot);
    out_free = !out_valid_r || out_ready;
  end

  wmmf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.update),
    .dividend (sum_mag),
    .divisor  (n_new_r),
    .done     (div_done),
    .quotient (quot)
  );

  // Memories: registered reads, writes at one address per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_q  <= raw_mem[{ch_r, slot_r}];
      mean_q <= mean_mem[{ch_r, slot_r}];
    end
    if (cmd.update) begin
      raw_mem[{ch_r, slot_r}]  <= x_r;
      mean_mem[{ch_r, slot_r}] <= med;
    end
    if (cmd.load || cmd.merge) begin
      sort_q <= sort_mem[{bank_cur, ch_r, rd_addr}];
    end
    if (sort_we) begin
      sort_mem[{!bank_cur, ch_r, w_r[wmmf_pkg::IDX_W-1:0]}] <= sort_wdata;
    end
  end

  // Item registers and merge bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r    <= in_channel;
      x_r     <= x_db;
      full_r  <= full_cur;
      n_old_r <= n_cur;
      n_new_r <= full_cur ? len : n_cur + 1'b1;
      slot_r  <= full_cur ? oldest_r[in_channel] : n_cur[wmmf_pkg::IDX_W-1:0];
      med_r   <= '0;
      mean_r  <= '0;
    end
    if (cmd.load) begin
      rd_idx_r   <= '0;
      w_r        <= '0;
      deleted_r  <= 1'b0;
      inserted_r <= 1'b0;
    end else if (cmd.merge && !merge_done) begin
      rd_idx_r <= rd_idx_nxt;
      if (take_del) deleted_r <= 1'b1;
      if (take_ins) inserted_r <= 1'b1;
      if (sort_we) begin
        w_r <= w_r + 1'b1;
        if (w_r == lo_idx) lo_r <= sort_wdata;
        if (w_r == hi_idx) hi_r <= sort_wdata;
      end
    end
    if (cmd.update) begin
      med_r <= med;
      neg_r <= sum_new[wmmf_pkg::SUM_W-1];
    end
    if (div_done) begin
      mean_r <= wmmf_pkg::SMP_W'(quot_s);
    end
  end

  // Configuration registers and per-channel history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= wmmf_pkg::WIN_LEN_RST;
      thr_r     <= wmmf_pkg::DB_THR_RST;
      mask_r    <= wmmf_pkg::DB_MASK_RST;
      bank_r    <= '0;
      for (int c = 0; c < wmmf_pkg::NUM_CH; c++) begin
        fill_r[c]   <= '0;
        oldest_r[c] <= '0;
        sum_r[c]    <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          wmmf_pkg::REG_WIN_LEN: begin
            win_len_r <= cfg_data[wmmf_pkg::LEN_W-1:0];
            for (int c = 0; c < wmmf_pkg::NUM_CH; c++) begin
              fill_r[c]   <= '0;
              oldest_r[c] <= '0;
              sum_r[c]    <= '0;
            end
          end
          wmmf_pkg::REG_DB_THR:  thr_r  <= cfg_data[wmmf_pkg::THR_W-1:0];
          wmmf_pkg::REG_DB_MASK: mask_r <= cfg_data[wmmf_pkg::MASK_W-1:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        fill_r[ch_r] <= n_new_r;
        sum_r[ch_r]  <= sum_new;
        bank_r[ch_r] <= !bank_r[ch_r];
        if (full_r) begin
          oldest_r[ch_r] <= (slot_inc == (wmmf_pkg::IDX_W+1)'(len)) ? '0
                            : slot_inc[wmmf_pkg::IDX_W-1:0];
        end
      end
    end
  end

  // Output register decouples the result from the next input word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish && out_free) begin
      out_ch_r   <= ch_r;
      out_med_r  <= med_r;
      out_mean_r <= mean_r;
    end
  end

  always_comb begin
    stat.bad_ch     = bad_ch;
    stat.merge_done = merge_done;
    stat.div_done   = div_done;
    stat.out_free   = out_free;
  end

  assign out_valid          = out_valid_r;
  assign out_channel_out    = out_ch_r;
  assign out_median_value   = out_med_r;
  assign out_filtered_value = out_mean_r;

endmodule

### rtl/core/wrench_median_mean_filter.sv
// Six-channel median-then-mean filter for force and torque words.
// An invalid channel goes straight to the finish state; otherwise the word passes
// through load, merge (one more step while the window is full), update, divide, finish;
// the sorted-window merge writes one entry a cycle and the serial divider takes 22 steps.
// A word is taken only once the last result is registered; a stalled result adds its wait.
// Reset clears all histories and loads window 40, threshold 26, mask force axes.
module wrench_median_mean_filter (
  input  logic            clk,
  input  logic            rst_n,
  wmmf_in_if.sink         in_ch,
  wmmf_out_if.source      out_ch,
  wmmf_cfg_if.sink        cfg_ch
);

  wmmf_pkg::wmmf_cmd_t  cmd;
  wmmf_pkg::wmmf_stat_t stat;
  logic                 in_ready;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  wmmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wmmf_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_channel         (in_ch.channel),
    .in_sample          (in_ch.sample),
    .cfg_valid          (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_channel_out    (out_ch.channel_out),
    .out_median_value   (out_ch.median_value),
    .out_filtered_value (out_ch.filtered_value)
  );

endmodule
